>>> rtl/core/sfr_pkg.sv
// Shared types, constants and the CRC16 byte update for the sync frame receiver.
// No dependencies.
package sfr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 4096;

	localparam logic [7:0] SYNC_BYTE_1 = 8'hA5;
	localparam logic [7:0] SYNC_BYTE_2 = 8'h5A;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [12:0] LEN_SAT = 13'h1FFF;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_BYTE = 3'd1;
	localparam logic [2:0] EV_ACCEPT = 3'd2;
	localparam logic [2:0] EV_OTHER = 3'd3;
	localparam logic [2:0] EV_CRCERR = 3'd4;
	localparam logic [2:0] EV_TOOLONG = 3'd5;

	localparam logic CFG_EXPECTED_CMD = 1'b0;
	localparam logic CFG_ACK_LENGTH = 1'b1;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic [11:0] byte_index;
		logic [7:0] frame_cmd;
		logic [12:0] frame_length;
	} result_t;

	// reflected CCITT, one byte
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] d;
		logic [15:0] r;
		d = b ^ crc[7:0];
		d = d ^ {d[3:0], 4'b0000};
		r = {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
		return r;
	endfunction

endpackage

>>> rtl/core/sync_frame_receiver_crc16_core.sv
// Sync-word frame receiver with running CRC16 and payload/end event reporting.
// Depends on sfr_pkg.
//
//  channel | signals                                        | direction
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata                | in
//  in      | in_valid, in_stall, rx_byte                    | in (stall out)
//  out     | out_valid, out_stall, event_res, data_byte,    | out (stall in)
//          | byte_index, frame_cmd, frame_length            |
//
// One byte per cycle while in_stall is low; each transfer in yields one registered result.
// The frame state updates at the input transfer; results go to an output
// register backed by a one-entry skid register, so in_stall rises only when
// both are full. Reset returns to the hunt for the first sync byte with
// expected_cmd 0 and ack_length 4096.
module sync_frame_receiver_crc16_core #(
	parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [11:0] byte_index,
	output logic [7:0]  frame_cmd,
	output logic [12:0] frame_length
);

	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

	localparam logic [2:0] PH_SYNC1 = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_CMD = 3'd2;
	localparam logic [2:0] PH_LENHI = 3'd3;
	localparam logic [2:0] PH_LENLO = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;
	localparam logic [2:0] PH_CRCHI = 3'd6;
	localparam logic [2:0] PH_CRCLO = 3'd7;

	logic [7:0] expected_cmd_q;
	logic [12:0] ack_length_q;
	logic [2:0] phase_q, phase_d;
	logic [7:0] cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0] crc_hi_q, crc_hi_d;
	logic [15:0] crc_q, crc_d;

	logic [16:0] cnt_ext, cnt_inc_ext;
	logic [2:0] ev;
	logic [7:0] ev_data;
	logic [11:0] ev_idx;
	sfr_pkg::result_t res;

	sfr_pkg::result_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic in_take, out_take;

	assign cnt_ext = 17'(cnt_q);
	assign cnt_inc_ext = cnt_ext + 17'd1;

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		len_d = len_q;
		cnt_d = cnt_q;
		crc_hi_d = crc_hi_q;
		crc_d = crc_q;
		ev = sfr_pkg::EV_NONE;
		ev_data = 8'h00;
		ev_idx = 12'h000;
		case (phase_q)
			PH_SYNC1: begin
				phase_d = (rx_byte == sfr_pkg::SYNC_BYTE_1) ? PH_SYNC2 : PH_SYNC1;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == sfr_pkg::SYNC_BYTE_2) ? PH_CMD : PH_SYNC1;
			end
			PH_CMD: begin
				cmd_d = rx_byte;
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_d = {8'h00, rx_byte};
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d = {len_q[7:0], rx_byte};
				cnt_d = '0;
				crc_d = sfr_pkg::CRC_INIT;
				if ({1'b0, len_d} > MAX_LEN) begin
					ev = sfr_pkg::EV_TOOLONG;
					phase_d = PH_SYNC1;
				end else if (len_d == 16'h0000) begin
					phase_d = PH_CRCHI;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d = sfr_pkg::crc_add(crc_q, rx_byte);
				if (cnt_ext < {4'h0, ack_length_q}) begin
					ev = sfr_pkg::EV_BYTE;
					ev_data = rx_byte;
					ev_idx = cnt_ext[11:0];
				end
				cnt_d = cnt_inc_ext[CW-1:0];
				if (cnt_inc_ext >= {1'b0, len_q})
					phase_d = PH_CRCHI;
			end
			PH_CRCHI: begin
				crc_hi_d = rx_byte;
				phase_d = PH_CRCLO;
			end
			PH_CRCLO: begin
				if ({crc_hi_q, rx_byte} != crc_q)
					ev = sfr_pkg::EV_CRCERR;
				else if (cmd_q == expected_cmd_q)
					ev = sfr_pkg::EV_ACCEPT;
				else
					ev = sfr_pkg::EV_OTHER;
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase

		res.event_res = ev;
		res.data_byte = ev_data;
		res.byte_index = ev_idx;
		if (ev == sfr_pkg::EV_NONE) begin
			res.frame_cmd = 8'h00;
			res.frame_length = 13'h0000;
		end else begin
			res.frame_cmd = cmd_d;
			res.frame_length = (len_d > 16'(sfr_pkg::LEN_SAT)) ? sfr_pkg::LEN_SAT : len_d[12:0];
		end
	end

	assign in_stall = skid_valid_q;
	assign in_take = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cmd_q <= 8'h00;
			ack_length_q <= 13'd4096;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sfr_pkg::CFG_EXPECTED_CMD: expected_cmd_q <= cfg_wdata[7:0];
				sfr_pkg::CFG_ACK_LENGTH: ack_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			cmd_q <= 8'h00;
			len_q <= 16'h0000;
			cnt_q <= '0;
			crc_hi_q <= 8'h00;
			crc_q <= sfr_pkg::CRC_INIT;
		end else if (in_take) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			crc_hi_q <= crc_hi_d;
			crc_q <= crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take || !out_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (in_take) begin
				if (out_take || !out_valid_q)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take || !out_valid_q)
				out_q <= skid_q;
		end else if (in_take) begin
			if (out_take || !out_valid_q)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_q.event_res;
	assign data_byte = out_q.data_byte;
	assign byte_index = out_q.byte_index;
	assign frame_cmd = out_q.frame_cmd;
	assign frame_length = out_q.frame_length;

endmodule
